// ===== src/hsvrgb_pkg.sv =====
// Package for the full-value HSV to RGB converter: level constants, sector
// codes and the hue sector split. No dependencies.
`default_nettype none

package hsvrgb_pkg;

    localparam logic [13:0] C_FULL_LEVEL  = 14'd10000;
    localparam logic [12:0] C_SECTOR_SPAN = 13'd6000;
    localparam logic [15:0] C_CIRCLE_SPAN = 16'd36000;
    // full level times sector span, the numerator before the products are taken off
    localparam logic [25:0] C_FULL_NUM    = 26'd60000000;
    // ceil(2^32 / 375): exact quotient for any 22 bit dividend
    localparam logic [23:0] C_RECIP       = 24'd11453247;

    localparam logic [2:0] SECT_0 = 3'd0;
    localparam logic [2:0] SECT_1 = 3'd1;
    localparam logic [2:0] SECT_2 = 3'd2;
    localparam logic [2:0] SECT_3 = 3'd3;
    localparam logic [2:0] SECT_4 = 3'd4;
    localparam logic [2:0] SECT_5 = 3'd5;

    typedef struct packed {
        logic [2:0]  sector;
        logic [12:0] rem;
    } t_hue_split;

    // Hue (already below 36000) into sector and remainder within the sector.
    function automatic t_hue_split hue_split(input logic [15:0] hue);
        t_hue_split res;
        logic [15:0] base;
        if (hue >= 16'd30000) begin
            res.sector = SECT_5;
            base       = 16'd30000;
        end else if (hue >= 16'd24000) begin
            res.sector = SECT_4;
            base       = 16'd24000;
        end else if (hue >= 16'd18000) begin
            res.sector = SECT_3;
            base       = 16'd18000;
        end else if (hue >= 16'd12000) begin
            res.sector = SECT_2;
            base       = 16'd12000;
        end else if (hue >= 16'd6000) begin
            res.sector = SECT_1;
            base       = 16'd6000;
        end else begin
            res.sector = SECT_0;
            base       = 16'd0;
        end
        res.rem = 13'(hue - base);
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== src/hsvrgb_div6000.sv =====
// Divide-by-6000 unit: takes the numerator already shifted right by four
// and divides by 375 with a reciprocal multiply. Depends on hsvrgb_pkg.
`default_nettype none

module hsvrgb_div6000 (
    input  wire logic [21:0] i_num_div16,
    output logic      [13:0] o_quot
);
    import hsvrgb_pkg::*;

    logic [45:0] prod;

    // quotient never exceeds 10000, so the top 14 bits carry all of it
    assign prod   = 46'(i_num_div16) * 46'(C_RECIP);
    assign o_quot = prod[45:32];

endmodule

`default_nettype wire

// ===== src/hsv_to_rgb_full_value.sv =====
// Top level of the full-value HSV to RGB converter: three register stages.
// Depends on hsvrgb_pkg and hsvrgb_div6000.
`default_nettype none

// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_ready    hue, saturation, quality
// output    out        o_out_valid / i_out_ready  red, green, blue, quality
//
// One color transaction is accepted per cycle unless stalled; its result passes
// the input, product and result registers in turn, is then offered and leaves
// when i_out_ready is high. The two multiply stages, the sector products and
// the reciprocal divide by 6000, are each followed by a register. Synchronous
// active-low reset clears only the stage valid bits. A stall at the output
// backs up stage by stage; empty stages keep filling.

module hsv_to_rgb_full_value (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [15:0] i_hue_centideg,
    input  wire logic [13:0] i_sat_centipct,
    input  wire logic [13:0] i_quality_centipct,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic      [13:0] o_red_level,
    output logic      [13:0] o_green_level,
    output logic      [13:0] o_blue_level,
    output logic      [13:0] o_quality_out
);
    import hsvrgb_pkg::*;

    // stage valid bits and load enables (bubbles collapse)
    logic r_v1, r_v2, r_v3;
    logic load1, load2, load3;

    assign load3      = !r_v3 || i_out_ready;
    assign load2      = !r_v2 || load3;
    assign load1      = !r_v1 || load2;
    assign o_in_ready = load1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (load1) r_v1 <= i_in_valid;
            if (load2) r_v2 <= r_v1;
            if (load3) r_v3 <= r_v2;
        end
    end

    // ---- stage 1: input register
    logic [15:0] r_hue;
    logic [13:0] r_sat;
    logic [13:0] r_qual1;

    always_ff @(posedge i_clk) begin
        if (load1) begin
            r_hue   <= i_hue_centideg;
            r_sat   <= i_sat_centipct;
            r_qual1 <= i_quality_centipct;
        end
    end

    // ---- stage 1 -> 2: wrap hue, split into sector, form numerators
    logic [15:0] hue_wrap;
    t_hue_split  split;
    logic [12:0] rem_rev;
    logic [26:0] prod_q, prod_t;
    logic [26:0] diff_q, diff_t;
    logic [21:0] n_num_q, n_num_t;
    logic [13:0] n_p;

    // a 16 bit hue is below twice the circle, so one subtract wraps it
    assign hue_wrap = (r_hue >= C_CIRCLE_SPAN) ? (r_hue - C_CIRCLE_SPAN) : r_hue;
    assign split    = hue_split(hue_wrap);
    assign rem_rev  = C_SECTOR_SPAN - split.rem;

    assign prod_q = 27'(r_sat) * 27'(split.rem);
    assign prod_t = 27'(r_sat) * 27'(rem_rev);
    assign diff_q = 27'(C_FULL_NUM) - prod_q;
    assign diff_t = 27'(C_FULL_NUM) - prod_t;

    // saturation over full scale drives the numerator negative: clamp to zero
    assign n_num_q = (prod_q >= 27'(C_FULL_NUM)) ? 22'd0 : diff_q[25:4];
    assign n_num_t = (prod_t >= 27'(C_FULL_NUM)) ? 22'd0 : diff_t[25:4];
    assign n_p     = (r_sat >= C_FULL_LEVEL) ? 14'd0 : (C_FULL_LEVEL - r_sat);

    // ---- stage 2: product register
    logic [2:0]  r_sector;
    logic [21:0] r_num_q, r_num_t;
    logic [13:0] r_p;
    logic [13:0] r_qual2;

    always_ff @(posedge i_clk) begin
        if (load2) begin
            r_sector <= split.sector;
            r_num_q  <= n_num_q;
            r_num_t  <= n_num_t;
            r_p      <= n_p;
            r_qual2  <= r_qual1;
        end
    end

    // ---- stage 2 -> 3: divide by 6000, route levels by sector
    logic [13:0] lvl_q, lvl_t;
    logic [13:0] n_red, n_green, n_blue;

    hsvrgb_div6000 u_div_q (
        .i_num_div16 (r_num_q),
        .o_quot      (lvl_q)
    );

    hsvrgb_div6000 u_div_t (
        .i_num_div16 (r_num_t),
        .o_quot      (lvl_t)
    );

    always_comb begin
        unique case (r_sector)
            SECT_0: begin
                n_red = C_FULL_LEVEL; n_green = lvl_t;        n_blue = r_p;
            end
            SECT_1: begin
                n_red = lvl_q;        n_green = C_FULL_LEVEL; n_blue = r_p;
            end
            SECT_2: begin
                n_red = r_p;          n_green = C_FULL_LEVEL; n_blue = lvl_t;
            end
            SECT_3: begin
                n_red = r_p;          n_green = lvl_q;        n_blue = C_FULL_LEVEL;
            end
            SECT_4: begin
                n_red = lvl_t;        n_green = r_p;          n_blue = C_FULL_LEVEL;
            end
            default: begin
                n_red = C_FULL_LEVEL; n_green = r_p;          n_blue = lvl_q;
            end
        endcase
    end

    // ---- stage 3: result register
    logic [13:0] r_red, r_green, r_blue, r_qual3;

    always_ff @(posedge i_clk) begin
        if (load3) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
            r_qual3 <= r_qual2;
        end
    end

    assign o_out_valid   = r_v3;
    assign o_red_level   = r_red;
    assign o_green_level = r_green;
    assign o_blue_level  = r_blue;
    assign o_quality_out = r_qual3;

endmodule

`default_nettype wire

// ===== src/hsvrgb_checker.sv =====
// Port-level checker for the HSV to RGB converter, bound to the top level.
// Depends on hsv_to_rgb_full_value.
`default_nettype none

module hsvrgb_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [13:0] o_red_level,
    input wire logic [13:0] o_green_level,
    input wire logic [13:0] o_blue_level
);

    // a pending result transaction is not dropped
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // an empty output stage never blocks the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    // levels never exceed full scale
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_red_level <= 14'd10000) && (o_green_level <= 14'd10000)
                        && (o_blue_level <= 14'd10000))
        else $error("level above full scale");

    // full value: some channel is always at full scale
    a_full_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_red_level == 14'd10000) || (o_green_level == 14'd10000)
                        || (o_blue_level == 14'd10000))
        else $error("no channel at full scale");

endmodule

bind hsv_to_rgb_full_value hsvrgb_checker u_hsvrgb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_red_level   (o_red_level),
    .o_green_level (o_green_level),
    .o_blue_level  (o_blue_level)
);

`default_nettype wire
